>>> hdl/sdsf_pkg.sv
// sdsf_pkg: codes, job type and CRC7 byte update for the SD session command framer.
// No dependencies; imported by every module of the block (the interfaces do not use it).
package sdsf_pkg;

  // request kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  // session state codes
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // command bytes (start and transmission bits included)
  localparam logic [7:0] CMD_STOP        = 8'h4C;
  localparam logic [7:0] CMD_READ_MULTI  = 8'h52;
  localparam logic [7:0] CMD_WRITE_MULTI = 8'h59;

  localparam logic [7:0] FRAME_IDLE_BYTE = 8'hFF;
  localparam logic [8:0] CRC7_POLY_SHL   = 9'h112;

  // byte index inside one seven-byte frame
  localparam logic [2:0] POS_IDLE  = 3'd0;
  localparam logic [2:0] POS_CMD   = 3'd1;
  localparam logic [2:0] POS_ARG3  = 3'd2;
  localparam logic [2:0] POS_ARG2  = 3'd3;
  localparam logic [2:0] POS_ARG1  = 3'd4;
  localparam logic [2:0] POS_ARG0  = 3'd5;
  localparam logic [2:0] POS_CRC   = 3'd6;

  localparam int unsigned BLOCK_SHIFT = 9;  // 512-byte blocks

  typedef struct packed {
    logic        stop;   // close the open session first
    logic        open;   // then open a new one
    logic [7:0]  cmd;
    logic [31:0] arg;
  } sdsf_job_t;

  // CRC7 (x^7 + x^3 + 1) kept left-aligned in a byte, bit 0 always zero
  function automatic logic [7:0] crc7_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [8:0] c;
    c = {1'b0, crc ^ data};
    for (int b = 0; b < 8; b++) begin
      c = {c[7:0], 1'b0};
      if (c[8]) begin
        c = c ^ CRC7_POLY_SHL;
      end
    end
    return c[7:0];
  endfunction

endpackage

>>> hdl/sdsf_if.sv
// Channel interfaces of the SD session command framer: request, frame byte, config.
// Uses nothing from sdsf_pkg; widths are fixed here.
interface sdsf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] block_addr;
  logic [15:0] block_count;
  modport source (output valid, kind, block_addr, block_count, input ready);
  modport sink   (input valid, kind, block_addr, block_count, output ready);
endinterface

interface sdsf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface sdsf_cfg_if;
  logic valid;
  logic ready;
  logic card_high_capacity;
  modport source (output valid, card_high_capacity, input ready);
  modport sink   (input valid, card_high_capacity, output ready);
endinterface

>>> hdl/sdsf_session.sv
// sdsf_session: session tracker; decides per request which frames to send.
// Uses sdsf_pkg and the request/config interfaces; feeds one job register.
module sdsf_session
  import sdsf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sdsf_req_if.sink    req_i,
  sdsf_cfg_if.sink    cfg_i,
  output logic        job_valid_o,
  output sdsf_job_t   job_o,
  input  logic        job_ready_i
);

  logic        hc_q;
  logic [1:0]  mode_q, mode_d;
  logic [31:0] exp_q, exp_d;
  logic        job_valid_q;
  sdsf_job_t   job_q, job_d;
  logic        accept;
  logic [1:0]  want;
  logic        is_xfer;
  logic        cont;

  assign req_i.ready = !job_valid_q || job_ready_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = req_i.valid && req_i.ready;

  assign is_xfer = (req_i.kind == KIND_READ) || (req_i.kind == KIND_WRITE);
  assign want    = (req_i.kind == KIND_READ) ? MODE_READ : MODE_WRITE;
  assign cont    = (mode_q == want) && (req_i.block_addr == exp_q);

  always_comb begin
    mode_d    = mode_q;
    exp_d     = exp_q;
    job_d     = '0;
    job_d.cmd = CMD_STOP;
    if (req_i.kind == KIND_CLOSE) begin
      job_d.stop = (mode_q != MODE_NONE);
      mode_d     = MODE_NONE;
    end else if (is_xfer) begin
      if (cont) begin
        exp_d = exp_q + 32'(req_i.block_count);
      end else begin
        job_d.stop = (mode_q != MODE_NONE);
        job_d.open = 1'b1;
        job_d.cmd  = (req_i.kind == KIND_READ) ? CMD_READ_MULTI : CMD_WRITE_MULTI;
        job_d.arg  = hc_q ? req_i.block_addr : (req_i.block_addr << BLOCK_SHIFT);
        mode_d     = want;
        exp_d      = req_i.block_addr + 32'(req_i.block_count);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q        <= 1'b0;
      mode_q      <= MODE_NONE;
      exp_q       <= '0;
      job_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        hc_q <= cfg_i.card_high_capacity;
      end
      if (accept) begin
        mode_q      <= mode_d;
        exp_q       <= exp_d;
        job_valid_q <= job_d.stop || job_d.open;
      end else if (job_ready_i) begin
        job_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

  // a queued job always carries at least one frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (job_q.stop || job_q.open))
    else $error("sdsf_session: empty job queued");

  // a job waiting on the serialiser is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && !job_ready_i) |=> (job_valid_q && $stable(job_q)))
    else $error("sdsf_session: pending job lost or changed");

endmodule

>>> hdl/sdsf_serializer.sv
// sdsf_serializer: turns one job into one or two seven-byte command frames.
// Uses sdsf_pkg (job type, CRC7 update) and the frame interface; output is registered.
module sdsf_serializer
  import sdsf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  sdsf_job_t   job_i,
  output logic        job_ready_o,
  sdsf_frame_if.source frame_o
);

  logic        busy_q;
  logic        stop_pend_q;
  logic        open_pend_q;
  logic [7:0]  cmd_q;
  logic [31:0] arg_q;
  logic [2:0]  pos_q;
  logic [7:0]  crc_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  logic [7:0]  cur_cmd;
  logic [31:0] cur_arg;
  logic [7:0]  cur_byte;
  logic        step;
  logic        final_byte;
  logic        load;

  assign cur_cmd = stop_pend_q ? CMD_STOP : cmd_q;
  assign cur_arg = stop_pend_q ? 32'd0 : arg_q;

  always_comb begin
    unique case (pos_q)
      POS_IDLE: cur_byte = FRAME_IDLE_BYTE;
      POS_CMD:  cur_byte = cur_cmd;
      POS_ARG3: cur_byte = cur_arg[31:24];
      POS_ARG2: cur_byte = cur_arg[23:16];
      POS_ARG1: cur_byte = cur_arg[15:8];
      POS_ARG0: cur_byte = cur_arg[7:0];
      POS_CRC:  cur_byte = crc_q | 8'h01;  // end bit
      default:  cur_byte = FRAME_IDLE_BYTE;
    endcase
  end

  assign step        = busy_q && (!out_valid_q || frame_o.ready);
  assign final_byte  = (pos_q == POS_CRC) && !(stop_pend_q && open_pend_q);
  assign job_ready_o = !busy_q || (step && final_byte);
  assign load        = job_valid_i && job_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      stop_pend_q <= 1'b0;
      open_pend_q <= 1'b0;
      pos_q       <= POS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q      <= 1'b1;
        stop_pend_q <= job_i.stop;
        open_pend_q <= job_i.open;
        pos_q       <= POS_IDLE;
      end else if (step) begin
        if (pos_q == POS_CRC) begin
          pos_q <= POS_IDLE;
          if (final_byte) begin
            busy_q <= 1'b0;
          end else begin
            stop_pend_q <= 1'b0;   // stop frame done, open frame follows
          end
        end else begin
          pos_q <= pos_q + 3'd1;
        end
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (frame_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= job_i.cmd;
      arg_q <= job_i.arg;
    end
    if (step) begin
      out_byte_q <= cur_byte;
      out_last_q <= final_byte;
      if (pos_q == POS_IDLE) begin
        crc_q <= '0;
      end else if (pos_q != POS_CRC) begin
        crc_q <= crc7_byte(crc_q, cur_byte);
      end
    end
  end

  assign frame_o.valid      = out_valid_q;
  assign frame_o.frame_byte = out_byte_q;
  assign frame_o.last_byte  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pos_q <= POS_CRC))
    else $error("sdsf_serializer: byte index out of frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (stop_pend_q || open_pend_q))
    else $error("sdsf_serializer: busy with no frame pending");

  // every frame opens with the idle byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (pos_q == POS_IDLE)) |=> (out_byte_q == FRAME_IDLE_BYTE && !out_last_q))
    else $error("sdsf_serializer: frame does not start with 0xFF");

endmodule

>>> hdl/sd_block_session_command_framer.sv
// sd_block_session_command_framer: top level of the SD multi-block session framer.
// Depends on sdsf_pkg, sdsf_if.sv, sdsf_session and sdsf_serializer.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------
//  req_i    | in  | valid/ready   | kind[1:0], block_addr[31:0], block_count[15:0]
//  frame_o  | out | valid/ready   | frame_byte[7:0], last_byte
//  cfg_i    | in  | valid/ready   | card_high_capacity (always ready)
//
// A request is taken every cycle while the job register is free; continuations
// and empty closes produce no bytes and never stall the input.
// A request that opens a session gives 7 bytes, 14 if it also closes one; the
// serialiser sends one byte per cycle while frame_o.ready is high.
// A request goes through the job register, the serialiser and the output register.
// The output register holds while frame_o.ready is low; the serialiser holds behind it.
// Reset clears the session (no session, expected block zero) and addressing to bytes.
module sd_block_session_command_framer
  import sdsf_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  sdsf_req_if.sink      req_i,
  sdsf_frame_if.source  frame_o,
  sdsf_cfg_if.sink      cfg_i
);

  logic      job_valid;
  logic      job_ready;
  sdsf_job_t job;

  sdsf_session u_session (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_i       (cfg_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  sdsf_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .frame_o     (frame_o)
  );

endmodule

>>> test/tb_top.sv
// tb_top: self-checking bench for sd_block_session_command_framer.
// Needs sdsf_pkg and sdsf_if.sv. The bench shadows the session state, builds the CRC7 frames it
// expects and checks every frame byte, in most tests under random stalls on both channels.
`timescale 1ns / 100ps

module tb_top;
  import sdsf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sdsf_req_if   req ();
  sdsf_frame_if frm ();
  sdsf_cfg_if   cfg ();

  sd_block_session_command_framer uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .frame_o (frm),
    .cfg_i   (cfg)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the block's session state and addressing mode
  logic [1:0]  sess_mode;
  logic [31:0] next_block;
  logic        block_addressing;

  frame_beat_t frames_due[$];
  int unsigned err_count;
  int unsigned cycle_count;
  bit          stall_on;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (err_count < 40) begin
      $display("MISMATCH at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    end
    err_count++;
  endtask

  // CRC7, x^7 + x^3 + 1, over command byte and argument, MSB first
  function automatic logic [6:0] crc7_of(input logic [39:0] body);
    logic [6:0] crc;
    logic       fb;
    crc = '0;
    for (int i = 39; i >= 0; i--) begin
      fb = body[i] ^ crc[6];
      crc = {crc[5:0], 1'b0};
      if (fb) begin
        crc = crc ^ 7'h09;
      end
    end
    return crc;
  endfunction

  task automatic queue_frame(input logic [7:0] cmd, input logic [31:0] arg);
    logic [7:0] bytes [7];
    bytes[0] = FRAME_IDLE_BYTE;
    bytes[1] = cmd;
    bytes[2] = arg[31:24];
    bytes[3] = arg[23:16];
    bytes[4] = arg[15:8];
    bytes[5] = arg[7:0];
    bytes[6] = {crc7_of({cmd, arg}), 1'b1};
    for (int i = 0; i < 7; i++) begin
      frames_due.push_back('{frame_byte: bytes[i], last_byte: 1'b0});
    end
  endtask

  task automatic predict_request(input logic [1:0] kind, input logic [31:0] addr,
                                 input logic [15:0] count);
    logic [1:0]  want;
    logic [31:0] arg;
    int          n_prior;
    frame_beat_t tail;
    n_prior = frames_due.size();
    case (kind)
      KIND_CLOSE: begin
        if (sess_mode != MODE_NONE) begin
          queue_frame(CMD_STOP, 32'd0);
          sess_mode = MODE_NONE;
        end
      end
      KIND_READ, KIND_WRITE: begin
        want = (kind == KIND_READ) ? MODE_READ : MODE_WRITE;
        if (!(sess_mode == want && addr == next_block)) begin
          if (sess_mode != MODE_NONE) begin
            queue_frame(CMD_STOP, 32'd0);
          end
          arg = block_addressing ? addr : (addr << BLOCK_SHIFT);
          queue_frame((kind == KIND_READ) ? CMD_READ_MULTI : CMD_WRITE_MULTI, arg);
          sess_mode = want;
          next_block = addr;
        end
        next_block = next_block + {16'd0, count};
      end
      default: begin
      end
    endcase
    if (frames_due.size() > n_prior) begin
      tail = frames_due.pop_back();
      tail.last_byte = 1'b1;
      frames_due.push_back(tail);
    end
  endtask

  task automatic send_request(input logic [1:0] kind, input logic [31:0] addr,
                              input logic [15:0] count);
    if (stall_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    req.valid       <= 1'b1;
    req.kind        <= kind;
    req.block_addr  <= addr;
    req.block_count <= count;
    do @(posedge clk_i); while (!req.ready);
    predict_request(kind, addr, count);
  endtask

  // stop sending and wait for every frame byte plus the pipeline tail
  task automatic settle();
    req.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic high_cap);
    settle();
    cfg.valid              <= 1'b1;
    cfg.card_high_capacity <= high_cap;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    block_addressing = high_cap;
  endtask

  task automatic test_byte_addressing();
    stall_on = 1'b1;
    send_request(KIND_CLOSE, 32'd0, 16'd0);           // nothing open
    send_request(KIND_READ, 32'd0, 16'd0);
    send_request(KIND_READ, 32'd0, 16'd1);            // continuation
    send_request(KIND_READ, 32'd1, 16'hFFFF);
    send_request(KIND_READ, 32'd5, 16'd0);            // address jump
    send_request(2'd3, 32'd5, 16'hFFFF);              // unused kind
    send_request(KIND_READ, 32'h0001_0000, 16'd3);
    send_request(KIND_WRITE, 32'h0001_0003, 16'd2);   // direction change
    send_request(KIND_WRITE, 32'h0001_0005, 16'd0);
    send_request(KIND_CLOSE, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(KIND_CLOSE, 32'd0, 16'd0);
    send_request(KIND_WRITE, 32'h0001_0005, 16'd1);   // reopen at the kept address
    send_request(KIND_READ, 32'hFFFF_FFFF, 16'd2);    // byte address and count wrap
    send_request(KIND_READ, 32'd1, 16'd0);
    send_request(KIND_WRITE, 32'h007F_FFFF, 16'd0);
    send_request(2'd3, 32'hAAAA_5555, 16'h5A5A);
    send_request(KIND_CLOSE, 32'd0, 16'd0);
    settle();
  endtask

  task automatic test_block_addressing();
    write_capacity(1'b1);
    stall_on = 1'b1;
    send_request(KIND_READ, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(KIND_READ, 32'h0000_FFFE, 16'd1);
    send_request(KIND_WRITE, 32'hAAAA_AAAA, 16'h5555);
    send_request(KIND_READ, 32'h5555_5555, 16'hAAAA);
    send_request(KIND_CLOSE, 32'd0, 16'd0);
    write_capacity(1'b0);
  endtask

  task automatic test_random_sessions(input int unsigned n_items, input bit calm);
    int unsigned done;
    int unsigned r;
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [15:0] count;
    done = 0;
    stall_on = !calm;
    while (done < n_items) begin
      if (!calm && done % 25 == 0) begin
        stall_on = ($urandom_range(0, 2) != 0);
      end
      r = $urandom_range(0, 99);
      count = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16));
      addr = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40) : $urandom;
      if (r < 50 && sess_mode != MODE_NONE) begin
        kind = (sess_mode == MODE_READ) ? KIND_READ : KIND_WRITE;
        addr = next_block;
      end else if (r < 70) begin
        kind = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
        if ($urandom_range(0, 3) == 0) begin
          addr = next_block;
        end
      end else if (r < 82) begin
        kind = KIND_CLOSE;
      end else if (r < 88) begin
        kind = 2'd3;
      end else begin
        kind = 2'($urandom_range(0, 3));
        count = 16'($urandom);
      end
      send_request(kind, addr, count);
      if (kind != 2'd3) begin
        done++;
      end
    end
    settle();
  endtask

  // ready stalls on the frame side
  initial begin
    frm.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (stall_on && $urandom_range(0, 7) == 0) begin
        frm.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        frm.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    frame_beat_t due;
    if (rst_ni && frm.valid && frm.ready) begin
      if (frames_due.size() == 0) begin
        report_mismatch("unexpected frame byte", frm.frame_byte, 8'h00);
      end else begin
        due = frames_due.pop_front();
        if (frm.frame_byte !== due.frame_byte) begin
          report_mismatch("frame_byte", frm.frame_byte, due.frame_byte);
        end
        if (frm.last_byte !== due.last_byte) begin
          report_mismatch("last_byte", {7'd0, frm.last_byte}, {7'd0, due.last_byte});
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    err_count = 0;
    cycle_count = 0;
    stall_on = 1'b0;
    sess_mode = MODE_NONE;
    next_block = '0;
    block_addressing = 1'b0;
    rst_ni                 <= 1'b0;
    req.valid              <= 1'b0;
    req.kind               <= KIND_READ;
    req.block_addr         <= '0;
    req.block_count        <= '0;
    cfg.valid              <= 1'b0;
    cfg.card_high_capacity <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_byte_addressing();
    test_block_addressing();
    test_random_sessions(75, 1'b0);
    write_capacity(1'b1);
    test_random_sessions(75, 1'b0);
    write_capacity(1'($urandom_range(0, 1)));
    test_random_sessions(75, 1'b0);
    write_capacity(1'b0);
    test_random_sessions(75, 1'b1);

    if (frames_due.size() != 0) begin
      report_mismatch("frame bytes never sent", 8'(frames_due.size()), 8'h00);
    end
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
